@@ design/smd_pkg.sv @@
// Shared types and constants for the SHA-1 / SHA-0 message digest core.
// No dependencies; every design file imports this package.
`default_nettype none

package smd_pkg;

	typedef logic [31:0] word_t;

	// Block geometry and round count.
	localparam int unsigned NumWords  = 16;
	localparam int unsigned NumChain  = 5;
	localparam int unsigned CountW    = 61;

	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [6:0] ROUND_P1   = 7'd20;
	localparam logic [6:0] ROUND_P2   = 7'd40;
	localparam logic [6:0] ROUND_P3   = 7'd60;

	// Initial chaining value.
	localparam word_t H0 = 32'h67452301;
	localparam word_t H1 = 32'hEFCDAB89;
	localparam word_t H2 = 32'h98BADCFE;
	localparam word_t H3 = 32'h10325476;
	localparam word_t H4 = 32'hC3D2E1F0;

	// Round constants.
	localparam word_t K0 = 32'h5A827999;
	localparam word_t K1 = 32'h6ED9EBA1;
	localparam word_t K2 = 32'h8F1BBCDC;
	localparam word_t K3 = 32'hCA62C1D6;

	// Padding marker byte.
	localparam logic [7:0] PAD_BYTE = 8'h80;

	// Request operation codes.
	localparam logic OP_ABSORB = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	// Index of the last digest word.
	localparam logic [2:0] LAST_WORD = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COMP,
		ST_PAD2,
		ST_OUT
	} smd_state_t;

	// Control from the sequencer to the compression engine.
	typedef struct packed {
		logic start;
		logic init;
		logic sha1;
	} smd_ctrl_t;

endpackage

`default_nettype wire

@@ design/smd_compress.sv @@
// Iterative compression engine: one round per cycle over a 16-word schedule window.
// Holds the message block and the chaining value. Depends on smd_pkg.
`default_nettype none

module smd_compress
	import smd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire smd_ctrl_t             ctrl,
	input  wire logic [15:0]           blk_we,
	input  wire logic [15:0][31:0]     blk_wd,
	output logic                       done,
	output logic [4:0][31:0]           chain
);

	word_t            win_q [NumWords];
	word_t            a_q, b_q, c_q, d_q, e_q;
	logic [4:0][31:0] chain_q;
	logic             busy_q;
	logic             add_q;
	logic [6:0]       rnd_q;

	word_t f_val;
	word_t k_val;
	word_t sched_x;
	word_t w_new;
	word_t t_val;

	// Round function, round constant and message expansion.
	always_comb begin
		if (rnd_q < ROUND_P1) begin
			f_val = d_q ^ (b_q & (c_q ^ d_q));
			k_val = K0;
		end else if (rnd_q < ROUND_P2) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K1;
		end else if (rnd_q < ROUND_P3) begin
			f_val = (b_q & c_q) | (d_q & (b_q | c_q));
			k_val = K2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K3;
		end
		sched_x = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
		w_new   = ctrl.sha1 ? {sched_x[30:0], sched_x[31]} : sched_x;
		t_val   = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + win_q[0];
	end

	// Schedule window: loaded word by word while idle, shifted during rounds.
	always_ff @(posedge clk) begin
		if (busy_q) begin
			for (int i = 0; i < NumWords - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[NumWords - 1] <= w_new;
		end else begin
			for (int i = 0; i < NumWords; i++) begin
				if (blk_we[i]) begin
					win_q[i] <= blk_wd[i];
				end
			end
		end
	end

	// Working variables.
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (busy_q) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	// Round counter and phase flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			add_q  <= 1'b0;
			rnd_q  <= '0;
		end else begin
			add_q <= busy_q && (rnd_q == LAST_ROUND);
			if (ctrl.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 7'd1;
				if (rnd_q == LAST_ROUND) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Chaining value: reinitialized per message, accumulated after each block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= {H4, H3, H2, H1, H0};
		end else if (ctrl.init) begin
			chain_q <= {H4, H3, H2, H1, H0};
		end else if (add_q) begin
			chain_q[0] <= chain_q[0] + a_q;
			chain_q[1] <= chain_q[1] + b_q;
			chain_q[2] <= chain_q[2] + c_q;
			chain_q[3] <= chain_q[3] + d_q;
			chain_q[4] <= chain_q[4] + e_q;
		end
	end

	assign done  = add_q;
	assign chain = chain_q;

endmodule

`default_nettype wire

@@ design/sha1_message_digest_core.sv @@
// SHA-1 / SHA-0 message digest core, top level: byte packing, padding
// sequencer and digest output. Depends on smd_pkg and smd_compress.
//
// The core takes one message byte per request. Every 64th byte starts a
// block compression (80 rounds in one shared round unit, then the chaining
// update) during which in_ready is low. A finish request pads the message
// and compresses one block, or two when fewer than 8 bytes remain after the
// marker byte; then the five digest words appear, word 0 first, one per
// out_valid/out_ready request; digest_last marks the fifth. The core then
// starts a new message. cfg_wr_data on cfg_wr_en selects SHA-1
// (1, reset value) or SHA-0 (0); change it only while the core is idle.
`default_nettype none

module sha1_message_digest_core
	import smd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        operation,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      digest_word,
	output logic             digest_last
);

	smd_state_t        state_q, state_d;
	logic [CountW-1:0] count_q;
	word_t             acc_q;
	logic              sha1_q;
	logic              pad2_q;
	logic              fin_q;
	logic [2:0]        idx_q;

	smd_ctrl_t         ctrl;
	logic [15:0]       blk_we;
	logic [15:0][31:0] blk_wd;
	logic              done;
	logic [4:0][31:0]  chain;

	logic              in_acc;
	logic              out_acc;
	logic [5:0]        pos;
	logic [3:0]        wi;
	logic [1:0]        lane;
	logic [7:0]        byte_sel;
	word_t             shifted;
	word_t             wd_word;
	word_t             len_hi;
	word_t             len_lo;

	// Byte placement within the current big-endian word.
	always_comb begin
		pos      = count_q[5:0];
		wi       = pos[5:2];
		lane     = pos[1:0];
		byte_sel = (operation == OP_FINISH) ? PAD_BYTE : data_byte;
		shifted  = {24'd0, byte_sel} << {~lane, 3'b000};
		wd_word  = ((lane == 2'd0) ? '0 : acc_q) | shifted;
		len_hi   = count_q[60:29];
		len_lo   = {count_q[28:0], 3'b000};
	end

	// Sequencer: next state, block writes and engine control.
	always_comb begin
		state_d     = state_q;
		blk_we      = '0;
		blk_wd      = '0;
		ctrl.start  = 1'b0;
		ctrl.init   = 1'b0;
		ctrl.sha1   = sha1_q;
		in_ready    = (state_q == ST_IDLE);
		out_valid   = (state_q == ST_OUT);
		digest_word = chain[idx_q];
		digest_last = (idx_q == LAST_WORD);
		in_acc      = in_valid && in_ready;
		out_acc     = out_valid && out_ready;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (operation == OP_ABSORB) begin
						blk_we[wi] = 1'b1;
						blk_wd[wi] = wd_word;
						if (pos == 6'd63) begin
							ctrl.start = 1'b1;
							state_d    = ST_COMP;
						end
					end else begin
						// Marker byte, then zero words up to the end of the block.
						for (int j = 0; j < NumWords; j++) begin
							if (4'(j) > wi) begin
								blk_we[j] = 1'b1;
							end
						end
						blk_we[wi] = 1'b1;
						blk_wd[wi] = wd_word;
						// Length field fits in this block unless the marker landed late.
						if (pos[5:3] != 3'b111) begin
							blk_wd[14] = len_hi;
							blk_wd[15] = len_lo;
						end
						ctrl.start = 1'b1;
						state_d    = ST_COMP;
					end
				end
			end
			ST_COMP: begin
				if (done) begin
					if (!fin_q) begin
						state_d = ST_IDLE;
					end else if (pad2_q) begin
						state_d = ST_PAD2;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_PAD2: begin
				// Extra block: all zeros and the length field.
				blk_we     = '1;
				blk_wd[14] = len_hi;
				blk_wd[15] = len_lo;
				ctrl.start = 1'b1;
				state_d    = ST_COMP;
			end
			ST_OUT: begin
				if (out_acc && digest_last) begin
					ctrl.init = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Message control state: byte count, finish flags and output index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pad2_q  <= 1'b0;
			fin_q   <= 1'b0;
			idx_q   <= '0;
			sha1_q  <= 1'b1;
		end else begin
			if (cfg_wr_en) begin
				sha1_q <= cfg_wr_data;
			end
			if (in_acc) begin
				if (operation == OP_ABSORB) begin
					count_q <= count_q + 61'd1;
				end else begin
					fin_q  <= 1'b1;
					pad2_q <= (pos[5:3] == 3'b111);
				end
			end
			if (state_q == ST_PAD2) begin
				pad2_q <= 1'b0;
			end
			if (out_acc) begin
				if (digest_last) begin
					idx_q   <= '0;
					fin_q   <= 1'b0;
					count_q <= '0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
		end
	end

	// Partial word being assembled from bytes.
	always_ff @(posedge clk) begin
		if (in_acc && (operation == OP_ABSORB)) begin
			acc_q <= wd_word;
		end
	end

	smd_compress u_compress (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.blk_we (blk_we),
		.blk_wd (blk_wd),
		.done   (done),
		.chain  (chain)
	);

endmodule

`default_nettype wire
